// ===== hw/rtl/dmd_pkg.sv =====
// Shared types, codes and reset values for the dual-unit task dispatcher.
package dmd_pkg;

    localparam int MAX_TASKS  = 7;
    localparam int TASK_IDX_W = 3;
    localparam int ENTRY_W    = 9;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK0_ENTRY = 3'd1;

    localparam logic [1:0] PLACE_ACCEL   = 2'd0;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_INFLIGHT = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;

    localparam logic [TASK_IDX_W-1:0] DONE_TOTAL_MAX = 3'd7;

    localparam logic [TASK_IDX_W-1:0] TASK_COUNT_RESET = 3'd4;
    localparam logic [MAX_TASKS-1:0][ENTRY_W-1:0] TASK_ENTRY_RESET = {
        9'd0, 9'd0, 9'd0, 9'd2, 9'd129, 9'd128, 9'd0
    };

    typedef struct packed {
        logic [TASK_IDX_W-1:0]             task_count;
        logic [MAX_TASKS-1:0][ENTRY_W-1:0] task_entry;
    } cfg_t;

    typedef struct packed {
        logic op;
        logic accel_finished;
        logic general_finished;
    } item_t;

    typedef struct packed {
        logic [MAX_TASKS-1:0][1:0]  status;
        logic [MAX_TASKS-1:0]       done_bits;
        logic [TASK_IDX_W-1:0]      done_total;
        logic                       accel_busy;
        logic [TASK_IDX_W-1:0]      accel_current;
        logic                       general_busy;
        logic [TASK_IDX_W-1:0]      general_current;
    } state_t;

    typedef struct packed {
        logic                  accel_issue_valid;
        logic [TASK_IDX_W-1:0] accel_issue_task;
        logic                  general_issue_valid;
        logic [TASK_IDX_W-1:0] general_issue_task;
        logic                  accel_retire_valid;
        logic [TASK_IDX_W-1:0] accel_retire_task;
        logic                  general_retire_valid;
        logic [TASK_IDX_W-1:0] general_retire_task;
        logic [MAX_TASKS-1:0]  finished_mask;
        logic                  all_finished;
    } result_t;

endpackage

// ===== hw/rtl/dmd_cfg_regs.sv =====
// Configuration register file: task count and per-task dependency/placement entries.
module dmd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmd_pkg::ENTRY_W-1:0]    cfg_wdata,
    output dmd_pkg::cfg_t                  cfg
);

    dmd_pkg::cfg_t cfg_reg;
    dmd_pkg::cfg_t cfg_next;
    logic [dmd_pkg::CFG_IDX_W-1:0] entry_sel;

    assign entry_sel = cfg_index - dmd_pkg::REG_TASK0_ENTRY;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            if (cfg_index == dmd_pkg::REG_TASK_COUNT) begin
                cfg_next.task_count = cfg_wdata[dmd_pkg::TASK_IDX_W-1:0];
            end else begin
                for (int i = 0; i < dmd_pkg::MAX_TASKS; i++) begin
                    if (entry_sel == dmd_pkg::CFG_IDX_W'(i)) begin
                        cfg_next.task_entry[i] = cfg_wdata;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.task_count <= dmd_pkg::TASK_COUNT_RESET;
            cfg_reg.task_entry <= dmd_pkg::TASK_ENTRY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dmd_sched.sv =====
// One scheduler step: ready scan, per-unit priority pick, retire and scoreboard update.
module dmd_sched (
    input  dmd_pkg::cfg_t    cfg,
    input  dmd_pkg::item_t   item,
    input  dmd_pkg::state_t  state,
    output dmd_pkg::state_t  state_next,
    output dmd_pkg::result_t result
);

    logic [dmd_pkg::MAX_TASKS-1:0]  accel_cand;
    logic [dmd_pkg::MAX_TASKS-1:0]  general_cand;
    logic                           accel_found;
    logic [dmd_pkg::TASK_IDX_W-1:0] accel_pick;
    logic                           general_found;
    logic [dmd_pkg::TASK_IDX_W-1:0] general_pick;
    logic                           accel_issue;
    logic                           general_issue;
    logic                           accel_busy_mid;
    logic [dmd_pkg::TASK_IDX_W-1:0] accel_cur_mid;
    logic                           general_busy_mid;
    logic [dmd_pkg::TASK_IDX_W-1:0] general_cur_mid;
    logic                           accel_retire;
    logic                           general_retire;
    logic [dmd_pkg::TASK_IDX_W:0]   total_sum;
    dmd_pkg::state_t                upd;

    always_comb begin
        for (int i = 0; i < dmd_pkg::MAX_TASKS; i++) begin
            logic [dmd_pkg::MAX_TASKS-1:0] deps;
            logic                          ready;
            deps  = cfg.task_entry[i][dmd_pkg::MAX_TASKS-1:0];
            ready = (dmd_pkg::TASK_IDX_W'(i) < cfg.task_count)
                 && (state.status[i] == dmd_pkg::ST_PENDING)
                 && ((deps & state.done_bits) == deps);
            accel_cand[i]   = ready && (cfg.task_entry[i][8:7] == dmd_pkg::PLACE_ACCEL);
            general_cand[i] = ready && (cfg.task_entry[i][8:7] != dmd_pkg::PLACE_ACCEL);
        end
    end

    // lowest index wins
    always_comb begin
        accel_found   = 1'b0;
        accel_pick    = '0;
        general_found = 1'b0;
        general_pick  = '0;
        for (int i = dmd_pkg::MAX_TASKS - 1; i >= 0; i--) begin
            if (accel_cand[i]) begin
                accel_found = 1'b1;
                accel_pick  = dmd_pkg::TASK_IDX_W'(i);
            end
            if (general_cand[i]) begin
                general_found = 1'b1;
                general_pick  = dmd_pkg::TASK_IDX_W'(i);
            end
        end
    end

    assign accel_issue      = accel_found && !state.accel_busy;
    assign general_issue    = general_found && !state.general_busy;
    assign accel_busy_mid   = state.accel_busy || accel_issue;
    assign accel_cur_mid    = accel_issue ? accel_pick : state.accel_current;
    assign general_busy_mid = state.general_busy || general_issue;
    assign general_cur_mid  = general_issue ? general_pick : state.general_current;
    assign accel_retire     = accel_busy_mid && item.accel_finished;
    assign general_retire   = general_busy_mid && item.general_finished;

    assign total_sum = {1'b0, state.done_total}
                     + {{dmd_pkg::TASK_IDX_W{1'b0}}, accel_retire}
                     + {{dmd_pkg::TASK_IDX_W{1'b0}}, general_retire};

    always_comb begin
        upd = state;
        for (int i = 0; i < dmd_pkg::MAX_TASKS; i++) begin
            if ((accel_issue && accel_pick == dmd_pkg::TASK_IDX_W'(i))
                || (general_issue && general_pick == dmd_pkg::TASK_IDX_W'(i))) begin
                upd.status[i] = dmd_pkg::ST_INFLIGHT;
            end
            if ((accel_retire && accel_cur_mid == dmd_pkg::TASK_IDX_W'(i))
                || (general_retire && general_cur_mid == dmd_pkg::TASK_IDX_W'(i))) begin
                upd.status[i]    = dmd_pkg::ST_DONE;
                upd.done_bits[i] = 1'b1;
            end
        end
        upd.done_total      = (total_sum > {1'b0, dmd_pkg::DONE_TOTAL_MAX})
                            ? dmd_pkg::DONE_TOTAL_MAX : total_sum[dmd_pkg::TASK_IDX_W-1:0];
        upd.accel_busy      = accel_busy_mid && !accel_retire;
        upd.accel_current   = accel_cur_mid;
        upd.general_busy    = general_busy_mid && !general_retire;
        upd.general_current = general_cur_mid;
    end

    always_comb begin
        result = '0;
        if (item.op) begin
            state_next = '0;
        end else begin
            state_next = upd;
            result.accel_issue_valid    = accel_issue;
            result.accel_issue_task     = accel_issue ? accel_pick : '0;
            result.general_issue_valid  = general_issue;
            result.general_issue_task   = general_issue ? general_pick : '0;
            result.accel_retire_valid   = accel_retire;
            result.accel_retire_task    = accel_retire ? accel_cur_mid : '0;
            result.general_retire_valid = general_retire;
            result.general_retire_task  = general_retire ? general_cur_mid : '0;
        end
        result.finished_mask = state_next.done_bits;
        result.all_finished  = state_next.done_total >= cfg.task_count;
    end

endmodule

// ===== hw/rtl/dependency_mask_dual_unit_dispatcher.sv =====
// Top level of the dual-unit dependency scoreboard dispatcher.
// Each request is a tick (op 0) or a restart (op 1) and yields exactly one result: a
// request is captured in an input register, the scan over all seven tasks, the per-unit
// pick and the retire run combinationally between that register and the output register,
// and the scoreboard updates as the request moves on. The result passes from the input
// register into the output register when that register is free, and is held there for as
// long as m_ready holds a waiting result. One request per cycle is sustained while m_ready
// is high; while a result waits the input register takes one more request and then
// s_ready drops until m_ready returns. Configuration writes belong to idle periods.
module dependency_mask_dual_unit_dispatcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmd_pkg::ENTRY_W-1:0]      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic                             s_accel_finished,
    input  logic                             s_general_finished,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_accel_issue_valid,
    output logic [dmd_pkg::TASK_IDX_W-1:0]   m_accel_issue_task,
    output logic                             m_general_issue_valid,
    output logic [dmd_pkg::TASK_IDX_W-1:0]   m_general_issue_task,
    output logic                             m_accel_retire_valid,
    output logic [dmd_pkg::TASK_IDX_W-1:0]   m_accel_retire_task,
    output logic                             m_general_retire_valid,
    output logic [dmd_pkg::TASK_IDX_W-1:0]   m_general_retire_task,
    output logic [dmd_pkg::MAX_TASKS-1:0]    m_finished_mask,
    output logic                             m_all_finished
);

    dmd_pkg::cfg_t    cfg;
    logic             in_valid_reg;
    dmd_pkg::item_t   in_item_reg;
    dmd_pkg::state_t  state_reg;
    dmd_pkg::state_t  state_next;
    logic             m_valid_reg;
    dmd_pkg::result_t result_reg;
    dmd_pkg::result_t result_next;
    logic             advance;
    logic             move;

    dmd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dmd_sched u_sched (
        .cfg        (cfg),
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance = !m_valid_reg || m_ready;
    assign move    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (move) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op               <= s_op;
            in_item_reg.accel_finished   <= s_accel_finished;
            in_item_reg.general_finished <= s_general_finished;
        end
        if (move) begin
            result_reg <= result_next;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_accel_issue_valid    = result_reg.accel_issue_valid;
    assign m_accel_issue_task     = result_reg.accel_issue_task;
    assign m_general_issue_valid  = result_reg.general_issue_valid;
    assign m_general_issue_task   = result_reg.general_issue_task;
    assign m_accel_retire_valid   = result_reg.accel_retire_valid;
    assign m_accel_retire_task    = result_reg.accel_retire_task;
    assign m_general_retire_valid = result_reg.general_retire_valid;
    assign m_general_retire_task  = result_reg.general_retire_task;
    assign m_finished_mask        = result_reg.finished_mask;
    assign m_all_finished         = result_reg.all_finished;

    // each retire sets a fresh finished bit
    a_total_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(state_reg.done_bits) == int'(state_reg.done_total))
        else $error("finished count out of step with finished mask");

    a_units_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.accel_busy && state_reg.general_busy
        |-> state_reg.accel_current != state_reg.general_current)
        else $error("same task in flight on both units");

    a_issue_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accel_issue_valid && m_general_issue_valid
        |-> m_accel_issue_task != m_general_issue_task)
        else $error("one task issued to both units");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !move |=> $stable(state_reg))
        else $error("scoreboard changed without a request moving");

endmodule

// ===== bench/dependency_mask_dual_unit_dispatcher_test.sv =====
// Self-checking bench for the dual-unit dispatcher: random requests and graphs vs a scoreboard model.
module dependency_mask_dual_unit_dispatcher_test;
    import dmd_pkg::*;

    localparam logic       OP_TICK       = 1'b0;
    localparam logic       OP_RESTART    = 1'b1;
    localparam logic [1:0] PLACE_GENERAL = 2'd1;
    localparam logic [1:0] PLACE_EITHER  = 2'd2;
    localparam logic [1:0] PLACE_CODE3   = 2'd3;
    localparam int         REQ_TARGET    = 1250;
    localparam int         LONG_HOLD     = 250;
    localparam int         CYCLE_LIMIT   = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ENTRY_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0;
    logic s_accel_finished = 1'b0;
    logic s_general_finished = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_accel_issue_valid;
    logic [TASK_IDX_W-1:0] m_accel_issue_task;
    logic m_general_issue_valid;
    logic [TASK_IDX_W-1:0] m_general_issue_task;
    logic m_accel_retire_valid;
    logic [TASK_IDX_W-1:0] m_accel_retire_task;
    logic m_general_retire_valid;
    logic [TASK_IDX_W-1:0] m_general_retire_task;
    logic [MAX_TASKS-1:0] m_finished_mask;
    logic m_all_finished;

    dependency_mask_dual_unit_dispatcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_accel_finished(s_accel_finished), .s_general_finished(s_general_finished),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_accel_issue_valid(m_accel_issue_valid), .m_accel_issue_task(m_accel_issue_task),
        .m_general_issue_valid(m_general_issue_valid),
        .m_general_issue_task(m_general_issue_task),
        .m_accel_retire_valid(m_accel_retire_valid), .m_accel_retire_task(m_accel_retire_task),
        .m_general_retire_valid(m_general_retire_valid),
        .m_general_retire_task(m_general_retire_task),
        .m_finished_mask(m_finished_mask), .m_all_finished(m_all_finished)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // configuration mirror and scoreboard model
    logic [TASK_IDX_W-1:0] cfg_count;
    logic [ENTRY_W-1:0]    cfg_entry [MAX_TASKS];
    logic [1:0]            sb_status [MAX_TASKS];
    logic [MAX_TASKS-1:0]  sb_done;
    logic [TASK_IDX_W-1:0] sb_total;
    logic                  acc_busy;
    logic [TASK_IDX_W-1:0] acc_task;
    logic                  gen_busy;
    logic [TASK_IDX_W-1:0] gen_task;

    item_t   pending_reqs [$];
    result_t expected_dispatch [$];
    int      failures = 0;
    int      reqs_queued = 0;
    int      results_seen = 0;
    int      cycle_count = 0;

    function automatic void clear_scoreboard();
        for (int t = 0; t < MAX_TASKS; t++) sb_status[t] = ST_PENDING;
        sb_done  = '0;
        sb_total = '0;
        acc_busy = 1'b0;
        acc_task = '0;
        gen_busy = 1'b0;
        gen_task = '0;
    endfunction

    function automatic void retire_task(input logic [TASK_IDX_W-1:0] t);
        sb_status[t] = ST_DONE;
        sb_done[t]   = 1'b1;
        if (sb_total != DONE_TOTAL_MAX) sb_total++;
    endfunction

    function automatic result_t dispatch_step(input item_t req);
        result_t              res;
        logic [MAX_TASKS-1:0] deps;
        logic [1:0]           place;
        res = '0;
        if (req.op == OP_RESTART) begin
            clear_scoreboard();
        end else begin
            for (int t = 0; t < MAX_TASKS; t++) begin
                deps  = cfg_entry[t][MAX_TASKS-1:0];
                place = cfg_entry[t][ENTRY_W-1:MAX_TASKS];
                if (t < cfg_count && sb_status[t] == ST_PENDING && (deps & sb_done) == deps) begin
                    if (place == PLACE_ACCEL) begin
                        if (!acc_busy) begin
                            acc_busy = 1'b1;
                            acc_task = 3'(t);
                            sb_status[t] = ST_INFLIGHT;
                            res.accel_issue_valid = 1'b1;
                            res.accel_issue_task  = 3'(t);
                        end
                    end else if (!gen_busy) begin
                        gen_busy = 1'b1;
                        gen_task = 3'(t);
                        sb_status[t] = ST_INFLIGHT;
                        res.general_issue_valid = 1'b1;
                        res.general_issue_task  = 3'(t);
                    end
                end
            end
            if (acc_busy && req.accel_finished) begin
                res.accel_retire_valid = 1'b1;
                res.accel_retire_task  = acc_task;
                retire_task(acc_task);
                acc_busy = 1'b0;
            end
            if (gen_busy && req.general_finished) begin
                res.general_retire_valid = 1'b1;
                res.general_retire_task  = gen_task;
                retire_task(gen_task);
                gen_busy = 1'b0;
            end
        end
        res.finished_mask = sb_done;
        res.all_finished  = (sb_total >= cfg_count);
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // request driver
    item_t cur_req;
    logic  tx_offer;
    int    tx_hold = 0;
    bit    tx_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_hold = 0;
        end else begin
            tx_offer = s_valid;
            if (s_valid && s_ready) begin
                expected_dispatch.push_back(dispatch_step(cur_req));
                tx_offer = 1'b0;
            end
            if (!tx_offer) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_op               <= cur_req.op;
                    s_accel_finished   <= cur_req.accel_finished;
                    s_general_finished <= cur_req.general_finished;
                    tx_offer = 1'b1;
                    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                    tx_hold = tx_burst ? 0 : $urandom_range(0, 15);
                end
            end
            s_valid <= tx_offer;
        end
    end

    // result monitor
    result_t want;
    int      rx_hold = 0;
    bit      rx_burst = 1'b0;
    bit      long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dispatch.size() == 0) begin
                    $error("result with no request outstanding");
                    failures++;
                end else begin
                    want = expected_dispatch.pop_front();
                    check_field("accel_issue_valid", want.accel_issue_valid, m_accel_issue_valid);
                    check_field("accel_issue_task", want.accel_issue_task, m_accel_issue_task);
                    check_field("general_issue_valid", want.general_issue_valid,
                                m_general_issue_valid);
                    check_field("general_issue_task", want.general_issue_task,
                                m_general_issue_task);
                    check_field("accel_retire_valid", want.accel_retire_valid,
                                m_accel_retire_valid);
                    check_field("accel_retire_task", want.accel_retire_task, m_accel_retire_task);
                    check_field("general_retire_valid", want.general_retire_valid,
                                m_general_retire_valid);
                    check_field("general_retire_task", want.general_retire_task,
                                m_general_retire_task);
                    check_field("finished_mask", want.finished_mask, m_finished_mask);
                    check_field("all_finished", want.all_finished, m_all_finished);
                end
                results_seen++;
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
                if (!long_hold_done && results_seen == 60) begin
                    // long back-pressure so the block fills and stalls its input
                    rx_hold = LONG_HOLD;
                    long_hold_done = 1'b1;
                end else begin
                    rx_hold = rx_burst ? 0 : $urandom_range(0, 15);
                end
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // caller is at a clock edge; the write happens at the next edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_TASK_COUNT) cfg_count = val[TASK_IDX_W-1:0];
        else cfg_entry[idx - REG_TASK0_ENTRY] = val;
    endtask

    task automatic push_req(input logic op, input logic af, input logic gf);
        item_t req;
        req.op = op;
        req.accel_finished = af;
        req.general_finished = gf;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    task automatic wait_idle();
        cfg_wr_en <= 1'b0;
        while (pending_reqs.size() != 0 || s_valid || expected_dispatch.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int                   n_reqs;
        int                   pick;
        bit                   first_phase;
        logic [MAX_TASKS-1:0] deps;
        logic [1:0]           place;
        logic [ENTRY_W-1:0]   val;

        cfg_count = TASK_COUNT_RESET;
        for (int t = 0; t < MAX_TASKS; t++) cfg_entry[t] = TASK_ENTRY_RESET[t];
        clear_scoreboard();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // default graph: parallel issue, blocked general unit, same-tick retire, idle finish
        push_req(OP_RESTART, 1'b1, 1'b1);
        push_req(OP_TICK, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b1, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b1);
        push_req(OP_TICK, 1'b1, 1'b1);
        push_req(OP_TICK, 1'b1, 1'b1);
        push_req(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // either and code 3 placements, dependency beyond count, full-scale entries
        write_reg(REG_TASK_COUNT, 9'd3);
        write_reg(REG_TASK0_ENTRY + 3'd0, {PLACE_EITHER, 7'h00});
        write_reg(REG_TASK0_ENTRY + 3'd1, {PLACE_CODE3, 7'h01});
        write_reg(REG_TASK0_ENTRY + 3'd2, {PLACE_ACCEL, 7'h40});
        write_reg(REG_TASK0_ENTRY + 3'd3, 9'h1FF);
        write_reg(REG_TASK0_ENTRY + 3'd4, 9'h000);
        write_reg(REG_TASK0_ENTRY + 3'd5, {PLACE_ACCEL, 7'h7F});
        write_reg(REG_TASK0_ENTRY + 3'd6, {PLACE_EITHER, 7'h7F});
        push_req(OP_RESTART, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b1);
        push_req(OP_TICK, 1'b0, 1'b1);
        push_req(OP_TICK, 1'b1, 1'b1);
        push_req(OP_TICK, 1'b1, 1'b1);
        wait_idle();

        // self dependency, then task count lowered with tasks in flight
        write_reg(REG_TASK_COUNT, 9'd7);
        write_reg(REG_TASK0_ENTRY + 3'd3, {PLACE_GENERAL, 7'h08});
        push_req(OP_RESTART, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b0);
        push_req(OP_TICK, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_TASK_COUNT, 9'd1);
        push_req(OP_TICK, 1'b1, 1'b1);
        wait_idle();

        // task count zero
        write_reg(REG_TASK_COUNT, 9'd0);
        push_req(OP_TICK, 1'b1, 1'b0);
        push_req(OP_RESTART, 1'b0, 1'b1);
        wait_idle();

        first_phase = 1'b1;
        while (reqs_queued < REQ_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) val = 9'd0;
            else if (pick <= 3) val = 9'd7;
            else if (pick == 4) val = 9'd1;
            else val = 9'($urandom_range(1, 7));
            write_reg(REG_TASK_COUNT, val);
            if (first_phase || $urandom_range(0, 3) != 0) begin
                for (int t = 0; t < MAX_TASKS; t++) begin
                    case ($urandom_range(0, 9))
                        0: val = 9'($urandom_range(0, 511));
                        1: val = ($urandom_range(0, 1) != 0) ? 9'h1FF : 9'h000;
                        default: begin
                            // mostly acyclic: depend only on lower tasks
                            deps  = 7'($urandom & $urandom) & 7'((1 << t) - 1);
                            place = ($urandom_range(0, 15) == 0) ? PLACE_CODE3
                                                                 : 2'($urandom_range(0, 2));
                            val   = {place, deps};
                        end
                    endcase
                    write_reg(REG_TASK0_ENTRY + 3'(t), val);
                end
            end
            n_reqs = first_phase ? 200 : $urandom_range(20, 120);
            first_phase = 1'b0;
            push_req(($urandom_range(0, 7) != 0) ? OP_RESTART : OP_TICK,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (int k = 1; k < n_reqs; k++)
                push_req(($urandom_range(0, 29) == 0) ? OP_RESTART : OP_TICK,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (expected_dispatch.size() != 0) begin
            $error("%0d results never arrived", expected_dispatch.size());
            failures++;
        end
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/dmd_pkg.sv
hw/rtl/dmd_cfg_regs.sv
hw/rtl/dmd_sched.sv
hw/rtl/dependency_mask_dual_unit_dispatcher.sv
bench/dependency_mask_dual_unit_dispatcher_test.sv
